// ----- hdl/assert_macros.svh -----
// Assertion helpers, all clocked on clk_i and masked during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- hdl/ubts_pkg.sv -----
package ubts_pkg;

  localparam int TARGETS = 4;
  localparam int IDX_W   = (TARGETS > 1) ? $clog2(TARGETS) : 1;

  // operand and product widths of the shared multiplier
  localparam int MUL_A_W = 28;
  localparam int MUL_B_W = 12;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // transaction kinds
  localparam logic [1:0] KIND_RECORD = 2'd0;
  localparam logic [1:0] KIND_DECIDE = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_QUEUE_WEIGHT    = 3'd0;
  localparam logic [2:0] REG_DISTANCE_WEIGHT = 3'd1;
  localparam logic [2:0] REG_SWITCH_MARGIN   = 3'd2;
  localparam logic [2:0] REG_LEAVE_THRESHOLD = 3'd3;
  localparam logic [2:0] REG_KEEP_CHARGE     = 3'd4;
  localparam logic [2:0] REG_START_CHARGE    = 3'd5;
  localparam logic [2:0] REG_LOCK_TICKS      = 3'd6;
  localparam logic [2:0] REG_SENSE_RANGE     = 3'd7;

  typedef struct packed {
    logic [7:0]  queue;
    logic [7:0]  inbound;
    logic [15:0] distance;
    logic        stale;
    logic        blocked;
    logic [6:0]  noise;
  } rec_t;

  typedef struct packed {
    logic               en;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_op_t;

endpackage

// ----- hdl/ubts_mul.sv -----
module ubts_mul
  import ubts_pkg::*;
(
  input  logic              clk_i,
  input  mul_op_t           op_i,
  output logic [PROD_W-1:0] prod_o
);

  logic [PROD_W-1:0] prod_q;

  // registered product, held when idle
  always_ff @(posedge clk_i) begin
    if (op_i.en) begin
      prod_q <= PROD_W'(op_i.a) * PROD_W'(op_i.b);
    end
  end

  assign prod_o = prod_q;

endmodule

// ----- hdl/utility_bid_target_selector.sv -----
// Utility bid target selector.
// Input channel (in_valid_i/in_ready_o) carries three kinds of transaction:
// a target record write, a decide tick (charge, parked) and a clear of the
// current choice. Every input transaction yields exactly one result on the
// output channel (out_valid_o/out_ready_i): committed, chosen index, changed.
// Config writes come on cfg_valid_i/cfg_ready_o (always ready), index + data;
// the user must issue them only while the block is idle (not enforced here).
// Sequence: record, clear and unknown kinds go from accept to the finish
// state. A decide tick ends after the hard checks on a drop, while locked,
// or with no choice and too little charge to start; otherwise it scans all
// targets, skipping unusable ones. For each usable target the single shared
// multiplier forms wd*dist, then *(512-charge), then wq*q, before the compare.
// One transaction is in flight at a time; in_ready_o is high in idle only.
// A finished result sits in the output register; if the receiver stalls,
// the block still accepts one more transaction and holds its result until
// the output register frees up.
// Reset (async, active low) clears the choice, lock and output valid, and
// loads the config defaults. The target table has no reset: records must be
// written before a decide tick reads them.
`include "assert_macros.svh"

module utility_bid_target_selector
  import ubts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [3:0]  target_index_i,
  input  logic [7:0]  queue_count_i,
  input  logic [7:0]  inbound_count_i,
  input  logic [15:0] target_distance_i,
  input  logic        info_stale_i,
  input  logic        target_blocked_i,
  input  logic [6:0]  bid_noise_i,
  input  logic [8:0]  charge_i,
  input  logic        parked_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        committed_o,
  output logic [3:0]  chosen_index_o,
  output logic        changed_o,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;  // hard drop checks on current target
  localparam logic [2:0] S_M1     = 3'd2;  // usability test, wd*dist
  localparam logic [2:0] S_M2     = 3'd3;  // * (512 - charge)
  localparam logic [2:0] S_M3     = 3'd4;  // latch distance cost, wq*q
  localparam logic [2:0] S_M4     = 3'd5;  // score and compare
  localparam logic [2:0] S_END    = 3'd6;  // switch / take decision
  localparam logic [2:0] S_FINISH = 3'd7;  // push result

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TARGETS - 1);

  // ---------------------------------------------------------------- config
  logic [11:0] queue_weight_q, distance_weight_q;
  logic [15:0] switch_margin_q, leave_threshold_q, lock_ticks_q, sense_range_q;
  logic [8:0]  keep_charge_q, start_charge_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_weight_q    <= 12'd384;
      distance_weight_q <= 12'd90;
      switch_margin_q   <= 16'd205;
      leave_threshold_q <= 16'd77;
      keep_charge_q     <= 9'd64;
      start_charge_q    <= 9'd128;
      lock_ticks_q      <= 16'd30;
      sense_range_q     <= 16'd512;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_QUEUE_WEIGHT:    queue_weight_q    <= cfg_data_i[11:0];
        REG_DISTANCE_WEIGHT: distance_weight_q <= cfg_data_i[11:0];
        REG_SWITCH_MARGIN:   switch_margin_q   <= cfg_data_i;
        REG_LEAVE_THRESHOLD: leave_threshold_q <= cfg_data_i;
        REG_KEEP_CHARGE:     keep_charge_q     <= cfg_data_i[8:0];
        REG_START_CHARGE:    start_charge_q    <= cfg_data_i[8:0];
        REG_LOCK_TICKS:      lock_ticks_q      <= cfg_data_i;
        REG_SENSE_RANGE:     sense_range_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- table
  rec_t             table_q [TARGETS];
  rec_t             rd_rec;
  rec_t             wr_rec;
  logic             tbl_we;
  logic [IDX_W-1:0] rd_idx;

  assign wr_rec = '{queue:    queue_count_i,
                    inbound:  inbound_count_i,
                    distance: target_distance_i,
                    stale:    info_stale_i,
                    blocked:  target_blocked_i,
                    noise:    bid_noise_i};

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      table_q[target_index_i[IDX_W-1:0]] <= wr_rec;
    end
  end

  // ---------------------------------------------------------------- state
  logic [2:0]        state_q, state_d;
  logic              choice_valid_q, choice_valid_d;
  logic [IDX_W-1:0]  choice_idx_q, choice_idx_d;
  logic [15:0]       lock_q, lock_d;
  logic              old_valid_q, old_valid_d;
  logic [IDX_W-1:0]  old_idx_q, old_idx_d;
  logic [IDX_W-1:0]  scan_q, scan_d;
  logic              have_best_q, have_best_d;
  logic              have_cur_q, have_cur_d;
  logic              out_valid_q, out_valid_d;

  // datapath registers, no reset
  logic [8:0]        charge_q;
  logic              parked_q;
  logic [21:0]       dcost_q;
  logic signed [23:0] best_u_q, cur_u_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic              committed_q;
  logic [3:0]        chosen_q;
  logic              changed_q;

  logic              in_acc;
  logic              push_ok;
  logic              last_scan;
  logic              usable;
  logic              is_cur;
  logic [9:0]        fac;
  logic signed [23:0] u;
  logic signed [24:0] best_ext, cur_plus, thr;
  logic              beats_cur, below_thr;
  logic              drop_hard;

  mul_op_t           mul_op;
  logic [PROD_W-1:0] prod;

  ubts_mul u_mul (
    .clk_i  (clk_i),
    .op_i   (mul_op),
    .prod_o (prod)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign push_ok    = !out_valid_q || out_ready_i;
  assign tbl_we     = in_acc && (kind_i == KIND_RECORD) && (target_index_i < 4'(TARGETS));

  assign rd_idx    = (state_q == S_CHECK) ? choice_idx_q : scan_q;
  assign rd_rec    = table_q[rd_idx];
  assign last_scan = (scan_q == LAST_IDX);
  assign usable    = !rd_rec.stale && !rd_rec.blocked && (rd_rec.queue != 8'd0);
  assign is_cur    = choice_valid_q && (scan_q == choice_idx_q);
  assign fac       = 10'd512 - {1'b0, charge_q};

  // score in Q.8: wq*q + noise - 256*inbound - dcost
  assign u = $signed({4'b0, prod[19:0]}) + $signed({17'b0, rd_rec.noise})
           - $signed({8'b0, rd_rec.inbound, 8'b0}) - $signed({2'b0, dcost_q});

  assign best_ext  = {best_u_q[23], best_u_q};
  assign cur_plus  = {cur_u_q[23], cur_u_q} + $signed({9'b0, switch_margin_q});
  assign thr       = parked_q ? $signed({9'b0, leave_threshold_q}) : 25'sd0;
  assign beats_cur = best_ext > cur_plus;
  assign below_thr = best_ext < thr;
  assign drop_hard = rd_rec.blocked
                  || ((rd_rec.distance < sense_range_q) && (rd_rec.queue == 8'd0));

  // shared multiplier operand select
  always_comb begin
    mul_op = '{en: 1'b0, a: '0, b: '0};
    unique case (state_q)
      S_M1: mul_op = '{en: 1'b1, a: MUL_A_W'(rd_rec.distance), b: distance_weight_q};
      S_M2: mul_op = '{en: 1'b1, a: prod[MUL_A_W-1:0], b: MUL_B_W'(fac)};
      S_M3: mul_op = '{en: 1'b1, a: MUL_A_W'(rd_rec.queue), b: queue_weight_q};
      default: ;
    endcase
  end

  always_comb begin
    state_d        = state_q;
    choice_valid_d = choice_valid_q;
    choice_idx_d   = choice_idx_q;
    lock_d         = lock_q;
    old_valid_d    = old_valid_q;
    old_idx_d      = old_idx_q;
    scan_d         = scan_q;
    have_best_d    = have_best_q;
    have_cur_d     = have_cur_q;
    out_valid_d    = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          old_valid_d = choice_valid_q;
          old_idx_d   = choice_idx_q;
          state_d     = S_FINISH;
          unique case (kind_i)
            KIND_DECIDE: begin
              if (lock_q != 16'd0) begin
                lock_d = lock_q - 16'd1;
              end
              state_d = S_CHECK;
            end
            KIND_CLEAR: begin
              choice_valid_d = 1'b0;
              choice_idx_d   = '0;
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        state_d     = S_FINISH;
        scan_d      = '0;
        have_best_d = 1'b0;
        have_cur_d  = 1'b0;
        if (!choice_valid_q) begin
          if (charge_q >= start_charge_q && lock_q == 16'd0) begin
            state_d = S_M1;
          end
        end else if (charge_q < keep_charge_q || drop_hard) begin
          choice_valid_d = 1'b0;
          choice_idx_d   = '0;
          lock_d         = lock_ticks_q;
        end else if (lock_q == 16'd0) begin
          state_d = S_M1;
        end
      end
      S_M1: begin
        if (usable) begin
          state_d = S_M2;
        end else if (last_scan) begin
          state_d = S_END;
        end else begin
          scan_d = scan_q + IDX_W'(1);
        end
      end
      S_M2: state_d = S_M3;
      S_M3: state_d = S_M4;
      S_M4: begin
        if (is_cur) begin
          have_cur_d = 1'b1;
        end
        have_best_d = 1'b1;
        if (last_scan) begin
          state_d = S_END;
        end else begin
          scan_d  = scan_q + IDX_W'(1);
          state_d = S_M1;
        end
      end
      S_END: begin
        state_d = S_FINISH;
        if (choice_valid_q) begin
          if (have_best_q && best_idx_q != choice_idx_q && (!have_cur_q || beats_cur)) begin
            choice_idx_d = best_idx_q;
            lock_d       = lock_ticks_q;
          end
        end else if (have_best_q && !below_thr) begin
          choice_valid_d = 1'b1;
          choice_idx_d   = best_idx_q;
          lock_d         = lock_ticks_q;
        end
      end
      S_FINISH: begin
        if (push_ok) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      choice_valid_q <= 1'b0;
      choice_idx_q   <= '0;
      lock_q         <= '0;
      old_valid_q    <= 1'b0;
      old_idx_q      <= '0;
      scan_q         <= '0;
      have_best_q    <= 1'b0;
      have_cur_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      choice_valid_q <= choice_valid_d;
      choice_idx_q   <= choice_idx_d;
      lock_q         <= lock_d;
      old_valid_q    <= old_valid_d;
      old_idx_q      <= old_idx_d;
      scan_q         <= scan_d;
      have_best_q    <= have_best_d;
      have_cur_q     <= have_cur_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // datapath captures
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      charge_q <= charge_i;
      parked_q <= parked_i;
    end
    if (state_q == S_M3) begin
      dcost_q <= prod[37:16];
    end
    if (state_q == S_M4) begin
      if (is_cur) begin
        cur_u_q <= u;
      end
      // first target wins ties
      if (!have_best_q || u > best_u_q) begin
        best_u_q   <= u;
        best_idx_q <= scan_q;
      end
    end
    if (state_q == S_CHECK) begin
      best_u_q <= '0;
      cur_u_q  <= '0;
    end
    if (state_q == S_FINISH && push_ok) begin
      committed_q <= choice_valid_q;
      chosen_q    <= choice_valid_q ? 4'(choice_idx_q) : 4'd0;
      changed_q   <= (old_valid_q != choice_valid_q)
                  || (choice_valid_q && (old_idx_q != choice_idx_q));
    end
  end

  assign out_valid_o    = out_valid_q;
  assign committed_o    = committed_q;
  assign chosen_index_o = chosen_q;
  assign changed_o      = changed_q;

  // ---------------------------------------------------------------- checks
  `ASSERT_ALWAYS(a_scan_unlocked, (state_q == S_M1) |-> (lock_q == 16'd0), "scan while locked")
  `ASSERT_ALWAYS(a_accept_leaves_idle, in_acc |=> (state_q != S_IDLE), "accept left block idle")
  `ASSERT_NEVER(a_idle_index, out_valid_o && !committed_o && (chosen_index_o != 4'd0),
                "nonzero index while not committed")
  `ASSERT_ALWAYS(a_change_reloads, (state_q == S_END && choice_idx_d != choice_idx_q)
                 |=> (lock_q == lock_ticks_q), "choice change without lock reload")

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ubts_pkg::*;

  // Kind code the block must pass over without any effect.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int HOLD_LONG = 400;   // receiver hold-off, forces input backpressure
  localparam int SETTLE    = 25;    // settle time after a drain, longer than the slowest decide

  // Belief about one target, as written by a record transaction.
  typedef struct packed {
    logic [7:0]  queue;
    logic [7:0]  inbound;
    logic [15:0] span;      // distance, Q8.8 m
    logic        stale;
    logic        blocked;
    logic [6:0]  noise;
  } belief_t;

  typedef struct {
    logic [1:0] kind;
    logic [3:0] tgt;
    belief_t    rec;
    logic [8:0] charge;
    logic       parked;
  } bid_item_t;

  typedef struct packed {
    logic       committed;
    logic [3:0] index;
    logic       changed;
  } choice_t;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i = '0;
  logic [3:0]  target_index_i = '0;
  logic [7:0]  queue_count_i = '0;
  logic [7:0]  inbound_count_i = '0;
  logic [15:0] target_distance_i = '0;
  logic        info_stale_i = 1'b0;
  logic        target_blocked_i = 1'b0;
  logic [6:0]  bid_noise_i = '0;
  logic [8:0]  charge_i = '0;
  logic        parked_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        committed_o;
  logic [3:0]  chosen_index_o;
  logic        changed_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  utility_bid_target_selector dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .kind_i, .target_index_i, .queue_count_i,
    .inbound_count_i, .target_distance_i, .info_stale_i, .target_blocked_i,
    .bid_noise_i, .charge_i, .parked_i,
    .out_valid_o, .out_ready_i, .committed_o, .chosen_index_o, .changed_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the selector: registers (reset defaults), beliefs, choice
  // ---------------------------------------------------------------------------
  logic [11:0] w_queue   = 12'd384;
  logic [11:0] w_dist    = 12'd90;
  logic [15:0] sw_margin = 16'd205;
  logic [15:0] leave_thr = 16'd77;
  logic [8:0]  keep_chg  = 9'd64;
  logic [8:0]  start_chg = 9'd128;
  logic [15:0] lock_len  = 16'd30;
  logic [15:0] sense_rng = 16'd512;

  belief_t     belief [TARGETS];
  bit          have_target = 1'b0;
  logic [3:0]  target_sel = '0;
  int          lock_cnt = 0;

  // Q.8 bid: wq*q - 256*inbound - floor(wd*dist*(512-charge)/2^16) + noise
  function automatic longint bid_score(belief_t r, int chg);
    longint gain, crowd, travel;
    gain   = longint'(w_queue) * longint'(r.queue);
    crowd  = longint'(r.inbound) * 256;
    travel = (longint'(w_dist) * longint'(r.span) * longint'(512 - chg)) >>> 16;
    return gain - crowd - travel + longint'(r.noise);
  endfunction

  function automatic void run_decide(int chg, bit park);
    bit     have_best, have_cur;
    int     best_i, t;
    longint best_u, cur_u, u;
    belief_t cur;
    have_best = 1'b0;
    have_cur  = 1'b0;
    best_i    = 0;
    best_u    = 0;
    cur_u     = 0;
    if (lock_cnt > 0) lock_cnt--;
    if (!have_target && chg < start_chg) return;
    // hard facts drop the target regardless of the lock
    if (have_target) begin
      cur = belief[target_sel];
      if (chg < keep_chg || cur.blocked || (cur.span < sense_rng && cur.queue == 0)) begin
        have_target = 1'b0;
        target_sel  = '0;
        lock_cnt    = int'(lock_len);
        return;
      end
    end
    if (lock_cnt > 0) return;
    for (t = 0; t < TARGETS; t++) begin
      if (belief[t].stale || belief[t].blocked || belief[t].queue == 0) continue;
      u = bid_score(belief[t], chg);
      if (have_target && t == target_sel) begin
        cur_u    = u;
        have_cur = 1'b1;
      end
      // strict compare: lowest index wins a tie
      if (!have_best || u > best_u) begin
        best_u    = u;
        best_i    = t;
        have_best = 1'b1;
      end
    end
    if (have_target) begin
      // stale current target is unscored and loses to any best
      if (have_best && best_i != target_sel &&
          (!have_cur || best_u > cur_u + longint'(sw_margin))) begin
        target_sel = 4'(best_i);
        lock_cnt   = int'(lock_len);
      end
      return;
    end
    if (have_best && best_u >= (park ? longint'(leave_thr) : longint'(0))) begin
      have_target = 1'b1;
      target_sel  = 4'(best_i);
      lock_cnt    = int'(lock_len);
    end
  endfunction

  function automatic choice_t predict_choice(bid_item_t it);
    bit         old_v;
    logic [3:0] old_i;
    choice_t    res;
    old_v = have_target;
    old_i = target_sel;
    case (it.kind)
      KIND_RECORD: if (it.tgt < TARGETS) belief[it.tgt] = it.rec;
      KIND_DECIDE: run_decide(int'(it.charge), it.parked);
      KIND_CLEAR: begin
        have_target = 1'b0;
        target_sel  = '0;
      end
      default: ;
    endcase
    res.committed = have_target;
    res.index     = have_target ? target_sel : 4'd0;
    res.changed   = (old_v != have_target) || (have_target && old_i != target_sel);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: presents queued items at the falling edge, holds until taken
  // ---------------------------------------------------------------------------
  bid_item_t item_q[$];
  bid_item_t drv_item;
  bit        in_fire = 1'b0;     // set at the rising edge a transaction is taken
  int        tx_idle_pct = 14;
  int        rx_idle_pct = 14;

  always @(negedge clk_i) begin
    if (!in_valid_i || in_fire) begin
      if (item_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        drv_item = item_q.pop_front();
        kind_i            <= drv_item.kind;
        target_index_i    <= drv_item.tgt;
        queue_count_i     <= drv_item.rec.queue;
        inbound_count_i   <= drv_item.rec.inbound;
        target_distance_i <= drv_item.rec.span;
        info_stale_i      <= drv_item.rec.stale;
        target_blocked_i  <= drv_item.rec.blocked;
        bid_noise_i       <= drv_item.rec.noise;
        charge_i          <= drv_item.charge;
        parked_i          <= drv_item.parked;
        in_valid_i        <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls, short random hold-offs, and one long
  // hold-off on request so the block backs up into its input
  // ---------------------------------------------------------------------------
  bit hold_request = 1'b0;
  int hold_left = 0;

  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left    = HOLD_LONG;
      hold_request = 1'b0;
    end else if (hold_left == 0 && rx_idle_pct != 0 && $urandom_range(0, 499) == 0) begin
      hold_left = $urandom_range(10, 40);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: check the result transaction first, then predict the input one
  // ---------------------------------------------------------------------------
  choice_t   pending_q[$];
  choice_t   want, fresh;
  bid_item_t seen;
  int        errors = 0;
  int        n_items = 0, n_decides = 0, n_changes = 0, n_settings = 0;
  int        stall_run = 0, max_stall = 0;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result: committed %0b index %0d changed %0b",
                 $time, committed_o, chosen_index_o, changed_o);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (committed_o !== want.committed) begin
          $display("%0t: committed mismatch: expected %0b actual %0b",
                   $time, want.committed, committed_o);
          errors++;
        end
        if (chosen_index_o !== want.index) begin
          $display("%0t: chosen_index mismatch: expected %0d actual %0d",
                   $time, want.index, chosen_index_o);
          errors++;
        end
        if (changed_o !== want.changed) begin
          $display("%0t: changed mismatch: expected %0b actual %0b",
                   $time, want.changed, changed_o);
          errors++;
        end
      end
    end

    in_fire = rst_ni && in_valid_i && in_ready_o;
    if (in_fire) begin
      seen.kind         = kind_i;
      seen.tgt          = target_index_i;
      seen.rec.queue    = queue_count_i;
      seen.rec.inbound  = inbound_count_i;
      seen.rec.span     = target_distance_i;
      seen.rec.stale    = info_stale_i;
      seen.rec.blocked  = target_blocked_i;
      seen.rec.noise    = bid_noise_i;
      seen.charge       = charge_i;
      seen.parked       = parked_i;
      fresh = predict_choice(seen);
      pending_q.push_back(fresh);
      n_items++;
      if (seen.kind == KIND_DECIDE) n_decides++;
      if (fresh.changed) n_changes++;
    end

    // length of input backpressure, to show the long hold-off bit
    if (rst_ni && in_valid_i && !in_ready_o) stall_run++;
    else stall_run = 0;
    if (stall_run > max_stall) max_stall = stall_run;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Unused fields of every item carry random bits.
  function automatic bid_item_t noise_item();
    bid_item_t   it;
    logic [63:0] raw;
    raw       = {$urandom, $urandom};
    it.kind   = KIND_UNUSED;
    it.tgt    = 4'($urandom_range(0, 15));
    it.rec    = raw[40:0];
    it.charge = 9'($urandom_range(0, 511));
    it.parked = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic offer_record(int idx, int q, int inb, int span, bit st, bit bl, int nz);
    bid_item_t it;
    it = noise_item();
    it.kind        = KIND_RECORD;
    it.tgt         = 4'(idx);
    it.rec.queue   = 8'(q);
    it.rec.inbound = 8'(inb);
    it.rec.span    = 16'(span);
    it.rec.stale   = st;
    it.rec.blocked = bl;
    it.rec.noise   = 7'(nz);
    item_q.push_back(it);
  endtask

  task automatic offer_decide(int chg, bit pk);
    bid_item_t it;
    it = noise_item();
    it.kind   = KIND_DECIDE;
    it.charge = 9'(chg);
    it.parked = pk;
    item_q.push_back(it);
  endtask

  task automatic offer_plain(logic [1:0] k);
    bid_item_t it;
    it = noise_item();
    it.kind = k;
    item_q.push_back(it);
  endtask

  // Register write; the shadow copy follows at the accepting edge.
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_QUEUE_WEIGHT:    w_queue   = val[11:0];
      REG_DISTANCE_WEIGHT: w_dist    = val[11:0];
      REG_SWITCH_MARGIN:   sw_margin = val;
      REG_LEAVE_THRESHOLD: leave_thr = val;
      REG_KEEP_CHARGE:     keep_chg  = val[8:0];
      REG_START_CHARGE:    start_chg = val[8:0];
      REG_LOCK_TICKS:      lock_len  = val;
      REG_SENSE_RANGE:     sense_rng = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every item is taken and every result checked, then let the
  // block settle before the next register write.
  task automatic drain();
    while (item_q.size() != 0 || in_valid_i || pending_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Random traffic, mostly record updates and decide ticks with values near
  // the interesting ranges; ignored records and the unused kind ride along
  // without counting toward n.
  task automatic queue_random(int n);
    int done, roll;
    done = 0;
    while (done < n) begin
      roll = $urandom_range(0, 99);
      if (roll < 38) begin
        offer_record($urandom_range(0, TARGETS - 1),
                     ($urandom_range(0, 99) < 80) ? $urandom_range(0, 6)
                                                  : $urandom_range(0, 255),
                     ($urandom_range(0, 99) < 80) ? $urandom_range(0, 3)
                                                  : $urandom_range(0, 255),
                     ($urandom_range(0, 99) < 70) ? $urandom_range(0, 1500) :
                     ($urandom_range(0, 99) < 67) ? $urandom_range(0, 8000)
                                                  : $urandom_range(0, 65535),
                     $urandom_range(0, 99) < 12,
                     $urandom_range(0, 99) < 8,
                     ($urandom_range(0, 99) < 85) ? $urandom_range(0, 77)
                                                  : $urandom_range(0, 127));
        done++;
      end else if (roll < 42) begin
        offer_record($urandom_range(TARGETS, 15), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 65535),
                     $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 127));
      end else if (roll < 88) begin
        offer_decide(($urandom_range(0, 99) < 85) ? $urandom_range(0, 256)
                                                  : $urandom_range(257, 511),
                     $urandom_range(0, 1));
        done++;
      end else if (roll < 95) begin
        offer_plain(KIND_CLEAR);
        done++;
      end else begin
        offer_plain(KIND_UNUSED);
      end
    end
  endtask

  task automatic run_phase(int wq, int wd, int mg, int th, int kc, int sc, int lk,
                           int sr, int n, int idle, bit squeeze);
    write_reg(REG_QUEUE_WEIGHT, 16'(wq));
    write_reg(REG_DISTANCE_WEIGHT, 16'(wd));
    write_reg(REG_SWITCH_MARGIN, 16'(mg));
    write_reg(REG_LEAVE_THRESHOLD, 16'(th));
    write_reg(REG_KEEP_CHARGE, 16'(kc));
    write_reg(REG_START_CHARGE, 16'(sc));
    write_reg(REG_LOCK_TICKS, 16'(lk));
    write_reg(REG_SENSE_RANGE, 16'(sr));
    tx_idle_pct = idle;
    rx_idle_pct = idle;
    if (squeeze) hold_request = 1'b1;
    queue_random(n);
    drain();
    n_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int p;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part with the lock off, other registers at reset values.
    // All records are written before the first decide reads them.
    write_reg(REG_LOCK_TICKS, 16'd0);
    offer_record(0, 255, 0, 0, 0, 0, 127);         // strongest bid
    offer_record(1, 0, 255, 65535, 1, 1, 0);       // empty, stale, blocked
    offer_record(2, 3, 1, 300, 0, 0, 77);
    offer_record(3, 1, 0, 2000, 1, 0, 5);          // stale, never scored
    offer_record(15, 7, 7, 7, 0, 0, 7);            // index out of range
    offer_plain(KIND_UNUSED);
    offer_decide(0, 1);                            // too little charge to start
    offer_decide(511, 1);                          // charge past full, commits to 0
    offer_plain(KIND_UNUSED);                      // reports choice unchanged
    offer_decide(10, 0);                           // drop on low charge
    offer_decide(256, 0);                          // back on 0
    offer_record(0, 255, 0, 0, 0, 1, 127);
    offer_decide(256, 0);                          // drop: target blocked
    offer_decide(256, 0);                          // takes 2
    offer_record(2, 0, 1, 100, 0, 0, 77);
    offer_decide(300, 0);                          // drop: seen empty within range
    offer_record(2, 5, 0, 300, 0, 0, 40);
    offer_decide(300, 0);                          // takes 2 again
    offer_record(2, 5, 0, 300, 1, 0, 40);
    offer_record(0, 255, 0, 0, 0, 0, 127);
    offer_decide(256, 1);                          // current stale: moves to 0
    offer_plain(KIND_CLEAR);
    offer_record(8, 1, 2, 3, 1, 1, 4);             // index out of range
    offer_decide(200, 1);
    drain();
    n_settings++;

    // Random phases: reset values, both extremes, random settings, a long
    // lock. One phase runs with no idling, one with a long receiver hold-off.
    run_phase(384, 90, 205, 77, 64, 128, 30, 512, 200, 14, 1'b0);
    run_phase(4095, 0, 0, 0, 0, 0, 0, 0, 160, 14, 1'b0);
    run_phase(0, 4095, 65535, 65535, 256, 256, 1, 65535, 120, 14, 1'b0);
    for (p = 0; p < 5; p++) begin
      run_phase($urandom_range(64, 1024), $urandom_range(0, 400), $urandom_range(0, 600),
                $urandom_range(0, 600), $urandom_range(0, 160), $urandom_range(64, 256),
                $urandom_range(0, 3), $urandom_range(0, 2000), 150,
                (p == 1) ? 0 : 14, p == 3);
    end
    run_phase(384, 90, 205, 77, 64, 128, 65535, 512, 60, 14, 1'b0);

    $display("Covered %0d transactions under %0d register settings, %0d decide ticks.",
             n_items, n_settings, n_decides);
    $display("Choice changed %0d times; longest input backpressure %0d cycles.",
             n_changes, max_stall);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", pending_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
